FILE: hw/rtl/dtfp_pkg.sv
// Shared constants and helper functions for the decimal text to fixed-point converter.
// It has no dependencies. The top level imports it.
package dtfp_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned FracW  = 4;
  localparam int unsigned ChW    = 8;
  localparam int unsigned PhaseW = 2;

  // parser phase codes
  localparam logic [PhaseW-1:0] PH_IDLE = 2'd0;
  localparam logic [PhaseW-1:0] PH_INT  = 2'd1;
  localparam logic [PhaseW-1:0] PH_FRAC = 2'd2;

  localparam logic [ChW-1:0] CH_MINUS = 8'h2D;
  localparam logic [ChW-1:0] CH_POINT = 8'h2E;
  localparam logic [ChW-1:0] CH_ZERO  = 8'h30;
  localparam logic [ChW-1:0] CH_NINE  = 8'h39;

  localparam logic [FracW-1:0] FRAC_RESET = 4'd0;

  typedef logic [ValueW-1:0] word_t;

  // ten to the power k, modulo 2^32
  function automatic word_t pow10(input logic [FracW-1:0] k);
    word_t p;
    unique case (k)
      4'd0:  p = 32'd1;
      4'd1:  p = 32'd10;
      4'd2:  p = 32'd100;
      4'd3:  p = 32'd1000;
      4'd4:  p = 32'd10000;
      4'd5:  p = 32'd100000;
      4'd6:  p = 32'd1000000;
      4'd7:  p = 32'd10000000;
      4'd8:  p = 32'd100000000;
      4'd9:  p = 32'd1000000000;
      4'd10: p = 32'd1410065408;
      4'd11: p = 32'd1215752192;
      4'd12: p = 32'd3567587328;
      4'd13: p = 32'd1316134912;
      4'd14: p = 32'd276447232;
      default: p = 32'd2764472320;
    endcase
    return p;
  endfunction

  // largest magnitude that still fits a positive result after scaling by 10^k
  function automatic word_t pos_limit(input logic [FracW-1:0] k);
    word_t l;
    unique case (k)
      4'd0: l = 32'd2147483647;
      4'd1: l = 32'd214748364;
      4'd2: l = 32'd21474836;
      4'd3: l = 32'd2147483;
      4'd4: l = 32'd214748;
      4'd5: l = 32'd21474;
      4'd6: l = 32'd2147;
      4'd7: l = 32'd214;
      4'd8: l = 32'd21;
      4'd9: l = 32'd2;
      default: l = 32'd0;
    endcase
    return l;
  endfunction

endpackage

FILE: hw/rtl/decimal_text_to_fixed_point.sv
// Top level of the decimal text to fixed-point converter: parser state, end-of-number
// scaling and a two-deep result buffer. Depends on dtfp_pkg.
//
// A result is registered into out_value/out_overflow, or into the skid stage while they are held.
// Throughput: one character per cycle when in_ready is high; set by the single accumulator
//   update (acc*10+digit) and the one 32x32 scaling multiply, both done in the transfer's cycle.
// in_ready drops only while two results are waiting (output register and skid stage full).
// Reset (rst_n low, synchronous) clears phase, flags, accumulators, buffer valids and
//   frac_digits to 0; there is no clearing pass.
module decimal_text_to_fixed_point (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dtfp_pkg::FracW-1:0]    cfg_frac_digits,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_first,
  input  logic [dtfp_pkg::ChW-1:0]      in_ch,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [dtfp_pkg::ValueW-1:0] out_value,
  output logic                          out_overflow
);
  import dtfp_pkg::*;

  // configuration
  logic [FracW-1:0]  frac_r;

  // parser state; the accumulator is kept both as unsigned magnitude (for range
  // checks) and as the signed two's complement value (fed to the scaling multiply)
  logic [PhaseW-1:0] phase_r, phase_nxt;
  logic              neg_r, neg_nxt;
  word_t             mag_r, mag_nxt;
  word_t             sacc_r, sacc_nxt;
  logic [FracW-1:0]  places_r, places_nxt;
  logic              ovf_r, ovf_nxt;

  // effective state seen by this character (a first mark restarts the number)
  logic [PhaseW-1:0] cur_phase;
  logic              cur_neg;
  word_t             cur_mag;
  word_t             cur_sacc;
  logic [FracW-1:0]  cur_places;
  logic              cur_ovf;

  logic              accept;
  logic              is_digit;
  logic [3:0]        digit;
  logic [ValueW+3:0] mag_step;
  word_t             sacc10;
  logic              fin;
  word_t             res_value;
  word_t             limit;
  logic              res_ovf;

  // result buffer: output register plus one skid entry
  logic              out_valid_r;
  word_t             out_value_r;
  logic              out_ovf_r;
  logic              skid_valid_r;
  word_t             skid_value_r;
  logic              skid_ovf_r;
  logic              pop;
  logic              push;

  assign cfg_ready = 1'b1;
  assign in_ready  = ~skid_valid_r;
  assign accept    = in_valid & in_ready;

  always_comb begin
    cur_phase  = in_first ? PH_INT : phase_r;
    cur_neg    = in_first ? 1'b0 : neg_r;
    cur_mag    = in_first ? '0 : mag_r;
    cur_sacc   = in_first ? '0 : sacc_r;
    cur_places = in_first ? frac_r : places_r;
    cur_ovf    = in_first ? 1'b0 : ovf_r;
  end

  assign is_digit = (in_ch >= CH_ZERO) && (in_ch <= CH_NINE);
  assign digit    = 4'(in_ch - CH_ZERO);

  // one step of acc*10+digit, with a carry-out check on the magnitude
  assign mag_step = ({4'b0, cur_mag} << 3) + ({4'b0, cur_mag} << 1) + (ValueW+4)'(digit);
  assign sacc10   = (cur_sacc << 3) + (cur_sacc << 1);

  // parser next state
  always_comb begin
    phase_nxt  = cur_phase;
    neg_nxt    = cur_neg;
    mag_nxt    = cur_mag;
    sacc_nxt   = cur_sacc;
    places_nxt = cur_places;
    ovf_nxt    = cur_ovf;
    fin        = 1'b0;
    if (in_first && (in_ch == CH_MINUS)) begin
      neg_nxt = 1'b1;
    end else begin
      unique case (cur_phase)
        PH_INT: begin
          if (is_digit) begin
            mag_nxt  = mag_step[ValueW-1:0];
            sacc_nxt = cur_neg ? sacc10 - ValueW'(digit) : sacc10 + ValueW'(digit);
            ovf_nxt  = cur_ovf | (mag_step[ValueW+3:ValueW] != '0);
          end else if (in_ch == CH_POINT) begin
            phase_nxt = PH_FRAC;
          end else begin
            fin = 1'b1;
          end
        end
        PH_FRAC: begin
          if (is_digit && (cur_places != '0)) begin
            mag_nxt    = mag_step[ValueW-1:0];
            sacc_nxt   = cur_neg ? sacc10 - ValueW'(digit) : sacc10 + ValueW'(digit);
            ovf_nxt    = cur_ovf | (mag_step[ValueW+3:ValueW] != '0);
            places_nxt = cur_places - FracW'(1);
          end else begin
            fin = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (fin) begin
      phase_nxt  = PH_IDLE;
      places_nxt = '0;
    end
  end

  // End of number: the open fraction places scale by 10^k in one multiply.
  // The signed accumulator already carries the sign, so the wrapped product is
  // the final value. A magnitude above the limit for k means the scaled value
  // left the signed range (for k >= 10 any nonzero magnitude does).
  assign res_value = cur_sacc * pow10(cur_places);
  assign limit     = pos_limit(cur_places) + ValueW'(cur_neg && (cur_places == '0));
  assign res_ovf   = cur_ovf | (cur_mag > limit);

  assign push = accept & fin;
  assign pop  = out_valid_r & out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_r <= FRAC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      frac_r <= cfg_frac_digits;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      neg_r    <= 1'b0;
      mag_r    <= '0;
      sacc_r   <= '0;
      places_r <= '0;
      ovf_r    <= 1'b0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      neg_r    <= neg_nxt;
      mag_r    <= mag_nxt;
      sacc_r   <= sacc_nxt;
      places_r <= places_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  // result buffer control; the skid entry fills only when the output register
  // holds a result that is not being taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !out_ready) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_value_r <= skid_value_r;
        out_ovf_r   <= skid_ovf_r;
      end
    end else if (push) begin
      if (out_valid_r && !out_ready) begin
        skid_value_r <= res_value;
        skid_ovf_r   <= res_ovf;
      end else begin
        out_value_r <= res_value;
        out_ovf_r   <= res_ovf;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_overflow = out_ovf_r;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds a result while output register is empty");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_value_r) && $stable(out_ovf_r))
    else $error("waiting result changed or vanished");

  a_minus_opens: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_first && (in_ch == CH_MINUS) |=> (phase_r == PH_INT) && neg_r)
    else $error("leading minus did not open a negative number");

  a_frac_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_first && (phase_r == PH_FRAC) && is_digit && (places_r != '0)
    |=> (places_r == $past(places_r) - FracW'(1)) && (phase_r == PH_FRAC))
    else $error("fraction digit did not consume a place");
`endif

endmodule

FILE: tb/decimal_text_to_fixed_point_tb.sv
// Testbench for decimal_text_to_fixed_point: feeds ASCII number text through valid/ready,
// predicts each fixed-point result in a local parser model and checks every result transfer.
// Depends on dtfp_pkg and the top-level RTL only.
module decimal_text_to_fixed_point_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dtfp_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 11;
  localparam int SETTLE_CYCLES  = 4;
  localparam int HOLD_CYCLES    = 400;    // long receiver hold-off
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int CHARS_PER_PASS = 125;

  localparam logic [ChW-1:0] CH_SPACE = 8'h20;
  localparam logic [ChW-1:0] CH_COMMA = 8'h2C;
  localparam logic [ChW-1:0] CH_SLASH = 8'h2F;  // just below '0'
  localparam logic [ChW-1:0] CH_COLON = 8'h3A;  // just above '9'

  typedef enum logic [1:0] {RX_ALWAYS, RX_PATTERN, RX_COIN, RX_SPARSE} rx_mode_t;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     overflow;
  } fixed_result_t;

  // ---------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                     clk             = 1'b0;
  logic                     rst_n           = 1'b0;
  logic                     cfg_valid       = 1'b0;
  logic                     cfg_ready;
  logic [FracW-1:0]         cfg_frac_digits = '0;
  logic                     in_valid        = 1'b0;
  logic                     in_ready;
  logic                     in_first        = 1'b0;
  logic [ChW-1:0]           in_ch           = '0;
  logic                     out_valid;
  logic                     out_ready       = 1'b0;
  logic signed [ValueW-1:0] out_value;
  logic                     out_overflow;

  decimal_text_to_fixed_point i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_frac_digits(cfg_frac_digits),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_first       (in_first),
    .in_ch          (in_ch),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value      (out_value),
    .out_overflow   (out_overflow)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Parser model: mirrors the block's state, updated on every input transfer
  // ---------------------------------------------------------------------------
  logic [PhaseW-1:0] parse_phase  = PH_IDLE;
  logic              parse_neg    = 1'b0;
  logic [ValueW-1:0] magnitude    = '0;   // unsigned, wraps at 32 bits
  logic [FracW-1:0]  places_open  = '0;   // fraction digits still allowed
  logic              wrapped      = 1'b0; // sticky overflow of this number
  logic [FracW-1:0]  scale_digits = '0;   // local copy of frac_digits

  fixed_result_t results_due[$];          // predicted results, oldest first
  int unsigned   mismatches    = 0;
  int unsigned   chars_parsed  = 0;       // transfers the parser did not ignore
  int unsigned   burst_left    = 0;
  int unsigned   rx_hold_reqs  = 0;       // hold-off requests raised by the tests

  function automatic void times_ten_plus(input logic [3:0] digit);
    logic [63:0] wide;
    wide = {32'd0, magnitude} * 64'd10 + {60'd0, digit};
    if (wide[63:32] != 32'd0) wrapped = 1'b1;
    magnitude = wide[31:0];
  endfunction

  // End of number: pad the open fraction places, range-check, apply the sign.
  function automatic void close_number();
    fixed_result_t r;
    repeat (places_open) times_ten_plus(4'd0);
    places_open = '0;
    if (!parse_neg && magnitude > 32'h7FFF_FFFF) wrapped = 1'b1;
    if (parse_neg && magnitude > 32'h8000_0000) wrapped = 1'b1;
    r.value    = parse_neg ? (32'd0 - magnitude) : magnitude;
    r.overflow = wrapped;
    results_due.push_back(r);
    parse_phase = PH_IDLE;
  endfunction

  // Returns 1 when the character was consumed, 0 when the block ignores it.
  function automatic bit advance_parser(input logic first, input logic [ChW-1:0] ch);
    logic [ChW-1:0] offset;
    bit             is_num;
    offset = ch - CH_ZERO;
    is_num = (ch >= CH_ZERO) && (ch <= CH_NINE);
    if (first) begin
      // a first mark drops whatever number was still open
      parse_neg   = 1'b0;
      magnitude   = '0;
      wrapped     = 1'b0;
      places_open = scale_digits;
      parse_phase = PH_INT;
      if (ch == CH_MINUS) begin
        parse_neg = 1'b1;
        return 1'b1;
      end
    end
    if (parse_phase == PH_INT) begin
      if (is_num) times_ten_plus(offset[3:0]);
      else if (ch == CH_POINT) parse_phase = PH_FRAC;
      else close_number();
      return 1'b1;
    end
    if (parse_phase == PH_FRAC) begin
      if (is_num && places_open != '0) begin
        times_ten_plus(offset[3:0]);
        places_open--;
      end else begin
        close_number();
      end
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: compares each output transfer with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    fixed_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result: value %0d overflow %0b", $time, out_value,
                 out_overflow);
      end else begin
        want = results_due.pop_front();
        if (out_value !== want.value) begin
          mismatches++;
          $display("%0t value mismatch: expected %0d (%h) actual %0d (%h)", $time,
                   want.value, want.value, out_value, out_value);
        end
        if (out_overflow !== want.overflow) begin
          mismatches++;
          $display("%0t overflow mismatch: expected %0b actual %0b", $time,
                   want.overflow, out_overflow);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: its own stall pattern, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  rx_mode_t    rx_mode      = RX_ALWAYS;
  int unsigned rx_mode_left = 0;
  int unsigned rx_hold_left = 0;
  int unsigned rx_hold_seen = 0;
  int unsigned rx_tick      = 0;

  always @(posedge clk) begin
    if (rx_hold_reqs != rx_hold_seen) begin
      rx_hold_seen = rx_hold_reqs;
      rx_hold_left = HOLD_CYCLES;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_t'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(40, 160);
      end
      rx_mode_left--;
      rx_tick++;
      case (rx_mode)
        RX_ALWAYS:  out_ready <= 1'b1;
        RX_PATTERN: out_ready <= (rx_tick % 4 != 3);
        RX_COIN:    out_ready <= 1'($urandom_range(0, 1));
        default:    out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // One character transfer. Bursts of random length, random gaps between them;
  // valid stays up across back-to-back transfers.
  task automatic send_char(input logic first, input logic [ChW-1:0] ch);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_first <= first;
    in_ch    <= ch;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    if (advance_parser(first, ch)) chars_parsed++;
  endtask

  // Text with the first character marked; no closing character.
  task automatic send_text(input string text);
    for (int i = 0; i < text.len(); i++) send_char(i == 0, text[i]);
  endtask

  // Stop offering and wait until every predicted result has been seen.
  task automatic pause_until_drained();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // frac_digits is only changed with no number open and nothing in flight.
  task automatic set_scale(input logic [FracW-1:0] digits);
    if (parse_phase != PH_IDLE) send_char(1'b0, CH_SPACE);
    pause_until_drained();
    cfg_valid       <= 1'b1;
    cfg_frac_digits <= digits;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    scale_digits = digits;
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests (frac_digits at its reset value of 0 until changed)
  // ---------------------------------------------------------------------------
  task automatic test_idle_characters();
    // nothing open: these must vanish without a result
    send_char(1'b0, 8'h00);
    send_char(1'b0, 8'hFF);
  endtask

  task automatic test_signed_integers();
    send_text("-12");
    send_char(1'b0, 8'hFF);
    send_text("7");
    send_char(1'b0, CH_MINUS);  // a sign inside the number ends it
  endtask

  task automatic test_empty_and_lone_sign();
    send_char(1'b1, CH_MINUS);
    send_char(1'b0, 8'h00);
    send_char(1'b1, CH_SPACE);  // empty text gives zero
  endtask

  task automatic test_restart_mid_number();
    send_text("9");             // dropped by the next first mark
    send_text("5.");
    send_char(1'b0, CH_NINE);   // no fraction places at scale 0: ends the number
  endtask

  task automatic test_fraction_and_overflow();
    set_scale(4'd9);
    send_text("-2.1");
    send_char(1'b0, CH_SLASH);
    send_text("2.5");           // 2.5e9 does not fit a positive result
    send_char(1'b0, CH_COLON);
  endtask

  task automatic test_large_scale();
    set_scale(4'd15);           // scaling wraps and flags overflow
    send_text("1");
    send_char(1'b0, CH_SPACE);
  endtask

  // Receiver holds off while the sender keeps offering short numbers: the
  // result buffer fills and the input must stall until the hold ends.
  task automatic test_backpressure();
    rx_hold_reqs++;
    for (int n = 0; n < 12; n++) begin
      send_char(1'b1, 8'(CH_ZERO + $urandom_range(0, 9)));
      send_char(1'b0, CH_COMMA);
    end
    pause_until_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Random numbers: mostly well-formed text with random content, the rest
  // noise, missing terminators and restarts.
  // ---------------------------------------------------------------------------
  task automatic test_random_numbers(input logic [FracW-1:0] digits, input int unsigned count);
    longint      edge_vals[7] = '{64'd2147483647, 64'd2147483648, 64'd2147483649,
                                  64'd4294967295, 64'd4294967296, 64'd214748364,
                                  64'd21474836};
    int unsigned target;
    int unsigned roll;
    int unsigned n_int;
    int unsigned n_frac;
    string       text;
    logic [ChW-1:0] stop;
    set_scale(digits);
    target = chars_parsed + count;
    while (chars_parsed < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        pause_until_drained();
      end else if (roll < 17) begin
        send_char(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 2) == 0) text = "-";
        else text = "";
        if ($urandom_range(0, 9) == 0) begin
          // magnitudes right at the 32-bit limits
          text = {text, $sformatf("%0d", edge_vals[$urandom_range(0, 6)])};
        end else begin
          n_int = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 11) : $urandom_range(0, 4);
          repeat (n_int) text = {text, $sformatf("%0d", $urandom_range(0, 9))};
        end
        if ($urandom_range(0, 1) != 0) begin
          text   = {text, "."};
          n_frac = $urandom_range(0, digits + 1);
          repeat (n_frac) text = {text, $sformatf("%0d", $urandom_range(0, 9))};
        end
        case ($urandom_range(0, 9))
          0:       stop = CH_SPACE;
          1:       stop = 8'h00;
          2:       stop = 8'hFF;
          3:       stop = CH_MINUS;
          4:       stop = CH_POINT;
          5:       stop = 8'(CH_ZERO + $urandom_range(0, 9));
          6:       stop = CH_COMMA;
          default: stop = 8'($urandom_range(0, 255));
        endcase
        if (text.len() == 0) begin
          send_char(1'b1, stop);
        end else begin
          send_text(text);
          // now and then leave it open so the next first mark drops it
          if ($urandom_range(0, 9) != 0) send_char(1'b0, stop);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_characters();
    test_signed_integers();
    test_empty_and_lone_sign();
    test_restart_mid_number();
    test_fraction_and_overflow();
    test_large_scale();
    test_backpressure();

    test_random_numbers(4'd0, CHARS_PER_PASS);
    test_random_numbers(4'd9, CHARS_PER_PASS);
    test_random_numbers(4'($urandom_range(1, 8)), CHARS_PER_PASS);
    test_backpressure();
    test_random_numbers(4'd2, CHARS_PER_PASS);
    test_random_numbers(4'($urandom_range(10, 15)), CHARS_PER_PASS);
    test_random_numbers(4'($urandom_range(1, 8)), CHARS_PER_PASS);
    test_random_numbers(4'd9, CHARS_PER_PASS);
    test_random_numbers(4'd0, CHARS_PER_PASS);

    pause_until_drained();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
